### hw/rtl/slt_pkg.sv
// Shared types and constants for the sorted list table.
// Used by slt_cell, sorted_list_table and the testbench; depends on nothing else.
package slt_pkg;

  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int REQ_W     = 2;
  localparam int ECOUNT_W  = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EVAL,
    FSM_APPLY,
    FSM_READ
  } fsm_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                     eval;
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

### hw/rtl/slt_cell.sv
// One storage cell of the sorted list table chain.
// Depends on slt_pkg for the control struct and data width.
module slt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                             clk,
  input  slt_pkg::cell_ctl_t               ctl,
  input  logic [CNT_W-1:0]                 count,
  input  logic                             left_ge,
  input  logic signed [slt_pkg::DATA_W-1:0] left_entry,
  input  logic signed [slt_pkg::DATA_W-1:0] right_entry,
  input  logic signed [slt_pkg::DATA_W-1:0] head_entry,
  output logic signed [slt_pkg::DATA_W-1:0] entry,
  output logic                             ge,
  output logic                             eq
);
  import slt_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic occupied;
  logic take_new;
  logic signed [DATA_W-1:0] entry_next;

  assign occupied = MY_IDX < count;
  // The insert point is the first occupied cell at or above the value, or
  // the first free cell when no such cell exists.
  assign take_new = !left_ge && (ge || (MY_IDX == count));

  always_comb begin
    entry_next = entry;
    unique case (ctl.op)
      OP_HOLD: begin
        entry_next = entry;
      end
      OP_INSERT: begin
        if (left_ge) begin
          entry_next = left_entry;
        end else if (take_new) begin
          entry_next = ctl.value;
        end
      end
      OP_DELETE: begin
        if (ge) begin
          entry_next = right_entry;
        end
      end
      OP_ROTATE: begin
        if (MY_IDX == count - CNT_W'(1)) begin
          entry_next = head_entry;
        end else begin
          entry_next = right_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctl.eval) begin
      ge <= occupied && (entry >= ctl.value);
      eq <= occupied && (entry == ctl.value);
    end
  end

endmodule

### hw/rtl/sorted_list_table.sv
// Top level of the sorted list table: request sequencer, cell chain and
// response register. Depends on slt_pkg and slt_cell.
//
// Usage: requests arrive on req_valid/req_stall with req_type and value;
// responses leave on rsp_valid/rsp_stall with status, entry_value,
// entry_count and last. A transaction moves on a clock edge where valid is
// high and stall is low. Insert and delete give one response each. A
// read-out of a non-empty table gives one response per stored entry in
// ascending order with last set on the final one; an empty table answers
// a read-out or delete with a single "empty" response.
// Timing: a request is accepted only while the sequencer is idle. Insert,
// delete and an empty read-out pass a compare step in every cell, then a
// commit step that loads the response register, and return to idle. A
// read-out of a non-empty table then emits its entries, as the chain
// rotates by one cell per emitted entry.
// Reset (rst, synchronous) empties the table and drops any pending
// response; the entry registers themselves are not cleared. When the
// receiver stalls, the response register holds its transaction and the
// sequencer waits before issuing the next one; the request side may
// still be accepted while a finished response waits to be taken.
module sorted_list_table #(
  parameter int DEPTH = slt_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [slt_pkg::REQ_W-1:0]             req_type,
  input  logic signed [slt_pkg::DATA_W-1:0]     value,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic [slt_pkg::STATUS_W-1:0]          status,
  output logic signed [slt_pkg::DATA_W-1:0]     entry_value,
  output logic [slt_pkg::ECOUNT_W-1:0]          entry_count,
  output logic                                 last
);
  import slt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  // Sequencer state.
  fsm_t                     state, state_next;
  logic [REQ_W-1:0]         req_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]         count, count_next;
  logic [CNT_W-1:0]         remain, remain_next;

  // Chain wiring.
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] ent [DEPTH];
  logic [DEPTH-1:0]         ge_vec;
  logic [DEPTH-1:0]         eq_vec;
  logic                     found;

  // Response side.
  logic                     out_free;
  logic                     emit;
  status_t                  emit_status;
  logic signed [DATA_W-1:0] emit_value;
  logic                     emit_last;
  logic [CNT_W+ECOUNT_W-1:0] count_ext;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign found     = |eq_vec;
  assign req_stall = (state != FSM_IDLE);

  // The chain: each cell sees its neighbors' entries; the head cell's entry
  // wraps around to the last occupied cell during a read-out rotation.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     l_ge;
    logic signed [DATA_W-1:0] l_ent;
    logic signed [DATA_W-1:0] r_ent;
    if (i == 0) begin : g_first
      assign l_ge  = 1'b0;
      assign l_ent = ent[0];
    end else begin : g_mid
      assign l_ge  = ge_vec[i-1];
      assign l_ent = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_ent = ent[i];
    end else begin : g_inner
      assign r_ent = ent[i+1];
    end
    slt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .left_ge     (l_ge),
      .left_entry  (l_ent),
      .right_entry (r_ent),
      .head_entry  (ent[0]),
      .entry       (ent[i]),
      .ge          (ge_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (req_valid) begin
          state_next = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        state_next = FSM_APPLY;
      end
      FSM_APPLY: begin
        if (out_free) begin
          if ((req_q == REQ_READ) && (count != '0)) begin
            state_next = FSM_READ;
          end else begin
            state_next = FSM_IDLE;
          end
        end
      end
      FSM_READ: begin
        if (out_free && (remain == CNT_W'(1))) begin
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  // Output and datapath control.
  always_comb begin
    ctl.eval    = (state == FSM_EVAL);
    ctl.op      = OP_HOLD;
    ctl.value   = value_q;
    count_next  = count;
    remain_next = remain;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_value  = '0;
    emit_last   = 1'b1;
    unique case (state)
      FSM_IDLE, FSM_EVAL: begin
        emit = 1'b0;
      end
      FSM_APPLY: begin
        if (out_free) begin
          unique case (req_q)
            REQ_INSERT: begin
              emit = 1'b1;
              if (count == FULL_COUNT) begin
                emit_status = ST_FULL;
              end else begin
                ctl.op     = OP_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            REQ_DELETE: begin
              emit = 1'b1;
              if (count == '0) begin
                emit_status = ST_EMPTY;
              end else if (!found) begin
                emit_status = ST_NOTFOUND;
              end else begin
                ctl.op     = OP_DELETE;
                count_next = count - CNT_W'(1);
              end
            end
            REQ_READ: begin
              if (count == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                remain_next = count;
              end
            end
            default: begin
              // Unused request code: table untouched, plain ok response.
              emit = 1'b1;
            end
          endcase
        end
      end
      FSM_READ: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_value  = ent[0];
          emit_last   = (remain == CNT_W'(1));
          ctl.op      = OP_ROTATE;
          remain_next = remain - CNT_W'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign count_ext = {{ECOUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      count     <= '0;
      remain    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q   <= req_type;
      value_q <= value;
    end
    if (emit) begin
      status      <= emit_status;
      entry_value <= emit_value;
      entry_count <= count_ext[ECOUNT_W-1:0];
      last        <= emit_last;
    end
  end

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("stored count exceeds table depth");

  // The stored count only changes in the commit step.
  a_count_commit: assert property (@(posedge clk) disable iff (rst)
    (state != FSM_APPLY) |=> $stable(count))
    else $error("stored count changed outside the commit step");

  // An accepted request always goes to the compare step next.
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == FSM_EVAL))
    else $error("accepted request did not start a compare step");

  // A read-out in progress always has entries left to send.
  a_read_remain: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_READ) |-> ((remain != '0) && (remain <= count)))
    else $error("read-out running with no entries left");

  // A pending stalled response is never overwritten.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !emit)
    else $error("response overwritten while stalled");

endmodule

### tb/sorted_list_table_checker.sv
// Checker for the sorted list table: watches both channels, predicts the results of
// every accepted request and compares them with the responses. Depends on slt_pkg.
module sorted_list_table_checker #(
  parameter int DEPTH = slt_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  logic [slt_pkg::REQ_W-1:0]           req_type,
  input  logic signed [slt_pkg::DATA_W-1:0]   value,
  input  logic                                rsp_valid,
  input  logic                                rsp_stall,
  input  logic [slt_pkg::STATUS_W-1:0]        status,
  input  logic signed [slt_pkg::DATA_W-1:0]   entry_value,
  input  logic [slt_pkg::ECOUNT_W-1:0]        entry_count,
  input  logic                                last,
  output int                                  failures,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import slt_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] entry_value;
    logic [ECOUNT_W-1:0]      entry_count;
    logic                     last;
  } table_result_t;

  logic signed [DATA_W-1:0] sorted_vals [DEPTH];
  int unsigned              fill;
  table_result_t            awaited_q [$];

  initial begin
    failures = 0;
    pending  = 0;
    fill     = 0;
  end

  function automatic void push_result(status_t st, logic signed [DATA_W-1:0] ev,
                                      logic lst);
    table_result_t r;
    r.status      = st;
    r.entry_value = ev;
    r.entry_count = fill[ECOUNT_W-1:0];
    r.last        = lst;
    awaited_q.push_back(r);
  endfunction

  // Applies one request to the shadow table and queues the results it causes.
  function automatic void apply_request(logic [REQ_W-1:0] rt, logic signed [DATA_W-1:0] v);
    int unsigned pos;
    case (rt)
      REQ_INSERT: begin
        if (fill >= DEPTH) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < fill && sorted_vals[pos] < v) pos++;
          for (int unsigned i = fill; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[pos] = v;
          fill++;
          push_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (fill == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < fill && sorted_vals[pos] != v) pos++;
          if (pos == fill) begin
            push_result(ST_NOTFOUND, '0, 1'b1);
          end else begin
            for (int unsigned i = pos; i + 1 < fill; i++) sorted_vals[i] = sorted_vals[i+1];
            fill--;
            push_result(ST_OK, '0, 1'b1);
          end
        end
      end
      REQ_READ: begin
        if (fill == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill; i++)
            push_result(ST_OK, sorted_vals[i], (i + 1 == fill));
        end
      end
      default: begin
        push_result(ST_OK, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void report_failure(string msg);
    failures++;
    if (failures <= 10) $display("%t ERROR: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    table_result_t exp_r;
    if (rst) begin
      fill = 0;
      awaited_q.delete();
    end else begin
      // A response always belongs to an earlier request, so it is checked first.
      if (rsp_valid && !rsp_stall) begin
        if (awaited_q.size() == 0) begin
          report_failure($sformatf("unexpected result status=%0d value=%0d count=%0d last=%0d",
                                   status, entry_value, entry_count, last));
        end else begin
          exp_r = awaited_q.pop_front();
          if (status !== exp_r.status || entry_value !== exp_r.entry_value ||
              entry_count !== exp_r.entry_count || last !== exp_r.last)
            report_failure($sformatf(
              "expected status=%0d value=%0d count=%0d last=%0d, got %0d/%0d/%0d/%0d",
              exp_r.status, exp_r.entry_value, exp_r.entry_count, exp_r.last,
              status, entry_value, entry_count, last));
        end
      end
      if (req_valid && !req_stall) apply_request(req_type, value);
    end
    pending = awaited_q.size();
  end

endmodule

### tb/sorted_list_table_tb.sv
// Top of the sorted list table testbench: clock, reset, request and response traffic,
// watchdog and verdict. Depends on slt_pkg, sorted_list_table and the checker.
module sorted_list_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slt_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  // Request code with no operation behind it; the block must answer it with a
  // plain OK and leave the table alone.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;
  localparam int RANDOM_ITEMS = 460;
  // The long receiver hold must stay well below the watchdog limit.
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [REQ_W-1:0] req_type = REQ_INSERT;
  logic signed [DATA_W-1:0] value = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic signed [DATA_W-1:0] entry_value;
  logic [ECOUNT_W-1:0] entry_count;
  logic last;

  int failures;
  int pending;
  int rsp_count = 0;

  // Values that were inserted, so that most deletes hit a stored entry.
  logic signed [DATA_W-1:0] inserted_q [$];

  sorted_list_table #(.DEPTH(DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .value       (value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .entry_value (entry_value),
    .entry_count (entry_count),
    .last        (last)
  );

  sorted_list_table_checker #(.DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .value       (value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .entry_value (entry_value),
    .entry_count (entry_count),
    .last        (last),
    .failures    (failures),
    .pending     (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Count accepted response transactions; the receiver uses this to decide when
  // to start its long hold.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) rsp_count <= rsp_count + 1;
  end

  // Mostly no gap, sometimes a short one, and now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offers one request and returns at the first falling edge after its acceptance
  // with req_stall low. Valid stays high when the next call has no gap, so
  // back-to-back transactions only change the payload. Called at a falling edge.
  task automatic send_request(input logic [REQ_W-1:0] rt, input logic signed [DATA_W-1:0] v,
                              input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req_type  = rt;
    value     = v;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    if (rt == REQ_INSERT) begin
      inserted_q.push_back(v);
      if (inserted_q.size() > 64) void'(inserted_q.pop_front());
    end
  endtask

  // Picks a value for an insert: repeats of earlier values, the extremes of the
  // signed range, and plenty of fully random values.
  function automatic logic signed [DATA_W-1:0] insert_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && inserted_q.size() > 0)
      return inserted_q[$urandom_range(0, inserted_q.size() - 1)];
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: return DATA_MIN;
        1: return DATA_MAX;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // Delete values are mostly taken out of the list of earlier inserts, which
  // keeps the table draining; the rest are random and usually absent.
  function automatic logic signed [DATA_W-1:0] delete_value();
    int idx;
    logic signed [DATA_W-1:0] v;
    if (inserted_q.size() > 0 && $urandom_range(0, 99) < 80) begin
      idx = $urandom_range(0, inserted_q.size() - 1);
      v = inserted_q[idx];
      inserted_q.delete(idx);
      return v;
    end
    return $urandom;
  endfunction

  // Receiver: random stalls of mixed length, stretches without any stall, and
  // one long hold after a number of responses. During the hold the sender keeps
  // offering requests, so the block backs up and stalls its request side.
  initial begin
    int stall_left;
    int cyc;
    bit hold_done;
    stall_left = 0;
    cyc = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && rsp_count >= 150) begin
        hold_done = 1'b1;
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (stall_left > 0) begin
        rsp_stall = 1'b1;
        stall_left--;
      end else if ((cyc / 500) % 3 != 1 && $urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
        rsp_stall = (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for too
  // long.
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
      else idle++;
    end
    $display("Watchdog expired with %0d results outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int r;
    bit fill_phase;
    bit no_gaps;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed part. The table starts empty, so a read-out and a delete both
    // answer "empty", and the unused code must leave the table alone.
    send_request(REQ_READ, $urandom, 1'b0);
    send_request(REQ_DELETE, 32'sd5, 1'b0);
    send_request(REQ_UNUSED, $urandom, 1'b0);
    // Extremes of the signed range, a duplicate value and a negative one.
    send_request(REQ_INSERT, DATA_MAX, 1'b0);
    send_request(REQ_INSERT, DATA_MIN, 1'b0);
    send_request(REQ_INSERT, '0, 1'b0);
    send_request(REQ_INSERT, '0, 1'b0);
    send_request(REQ_INSERT, -1, 1'b0);
    send_request(REQ_READ, $urandom, 1'b0);
    // An absent value leaves the table as it is; a duplicate loses one copy.
    send_request(REQ_DELETE, 32'sd12345, 1'b0);
    send_request(REQ_DELETE, '0, 1'b0);
    send_request(REQ_READ, $urandom, 1'b0);
    // Fill the table to the brim, try once more, and read all of it back.
    repeat (DEPTH - 4) send_request(REQ_INSERT, $urandom, 1'b0);
    send_request(REQ_INSERT, $urandom, 1'b0);
    send_request(REQ_READ, $urandom, 1'b0);

    // Random part. Phases alternate between mostly filling and mostly draining
    // the table, so it passes through full and empty many times. Every third
    // block of fifty items goes without sender gaps.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      fill_phase = ((k / 40) % 2) == 0;
      no_gaps = ((k / 50) % 3) == 2;
      r = $urandom_range(0, 99);
      if (r < 12)
        send_request(REQ_READ, $urandom, no_gaps);
      else if (r < 14)
        send_request(REQ_UNUSED, $urandom, no_gaps);
      else if (r < (fill_phase ? 74 : 34))
        send_request(REQ_INSERT, insert_value(), no_gaps);
      else
        send_request(REQ_DELETE, delete_value(), no_gaps);
    end
    req_valid = 1'b0;

    // Let every expected result arrive, then give the block time to show any
    // result that nobody asked for.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sorted_list_table.f
hw/rtl/slt_pkg.sv
hw/rtl/slt_cell.sv
hw/rtl/sorted_list_table.sv
tb/sorted_list_table_checker.sv
tb/sorted_list_table_tb.sv
